### rtl/broadcast_ring_queue_top_assert.svh
// assertion macros used by the broadcast ring queue back end
`ifndef BROADCAST_RING_QUEUE_TOP_ASSERT_SVH
`define BROADCAST_RING_QUEUE_TOP_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define BRQ_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define BRQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/brq_pkg.sv
// types and constants of the broadcast ring queue
package brq_pkg;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_NEWEST = 2'd2;
    localparam logic [1:0] FUNC_ATTACH = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  reader_id;
        logic [63:0] payload;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [63:0] data_out;
        logic [31:0] seq_out;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_NEWEST,
        OP_ATTACH,
        OP_REJECT
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [2:0]  reader;
        logic [63:0] payload;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } back_state_t;

endpackage

### rtl/brq_front.sv
// front end: accepts commands and classifies them into queue ops
module brq_front #(
    parameter int NUM_READERS = 8,
    parameter int DATA_WIDTH  = 64
) (
    input  logic                   start,
    output logic                   busy,
    input  brq_pkg::cmd_t          cmd,
    input  brq_pkg::queue_status_t q_status,
    output logic                   push,
    output brq_pkg::op_t           push_op
);

    localparam logic [63:0] DATA_MASK = {64{1'b1}} >> (64 - DATA_WIDTH);

    brq_pkg::op_kind_t kind;
    logic              reader_bad;

    assign busy       = q_status.full;
    assign push       = start && !q_status.full;
    assign reader_bad = {29'd0, cmd.reader_id} >= 32'(NUM_READERS);

    always_comb
    begin
        case (cmd.func)
            brq_pkg::FUNC_WRITE:  kind = brq_pkg::OP_WRITE;
            brq_pkg::FUNC_READ:   kind = brq_pkg::OP_READ;
            brq_pkg::FUNC_NEWEST: kind = brq_pkg::OP_NEWEST;
            brq_pkg::FUNC_ATTACH: kind = brq_pkg::OP_ATTACH;
            default:              kind = brq_pkg::OP_REJECT;
        endcase
        if (kind != brq_pkg::OP_WRITE && reader_bad)
        begin
            kind = brq_pkg::OP_REJECT;
        end
    end

    always_comb
    begin
        push_op.kind    = kind;
        push_op.reader  = cmd.reader_id;
        push_op.payload = cmd.payload & DATA_MASK;
    end

endmodule

### rtl/brq_queue.sv
// short op queue between front and back
module brq_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  brq_pkg::op_t           push_op,
    input  logic                   pop,
    output brq_pkg::op_t           head_op,
    output brq_pkg::queue_status_t status
);

    localparam int PW = (brq_pkg::QUEUE_DEPTH > 1) ? $clog2(brq_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(brq_pkg::QUEUE_DEPTH + 1);

    brq_pkg::op_t    entry_reg [brq_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == CW'(brq_pkg::QUEUE_DEPTH));
    assign head_op      = entry_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(brq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(brq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### rtl/brq_back.sv
// back end: ring slot memories, write counter, reader cursors and results
`include "broadcast_ring_queue_top_assert.svh"

module brq_back #(
    parameter int DEPTH       = 1024,
    parameter int NUM_READERS = 8,
    parameter int DATA_WIDTH  = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  brq_pkg::queue_status_t q_status,
    input  brq_pkg::op_t           q_op,
    output logic                   q_pop,
    output logic                   rsp_valid,
    output brq_pkg::rsp_t          rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int RW = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    brq_pkg::back_state_t  state_reg, state_next;

    logic [31:0]           count_reg, count_next;
    logic [AW-1:0]         wslot_reg, wslot_next;
    logic                  filled_reg, filled_next;

    logic [31:0]           cursor_reg [NUM_READERS];
    logic [AW-1:0]         cslot_reg  [NUM_READERS];
    logic                  cur_we;
    logic [RW-1:0]         cur_idx;
    logic [31:0]           cur_val;
    logic [AW-1:0]         cur_slot;

    brq_pkg::op_kind_t     pend_kind_reg, pend_kind_next;
    logic [RW-1:0]         pend_idx_reg, pend_idx_next;
    logic [31:0]           pend_cursor_reg, pend_cursor_next;
    logic [AW-1:0]         pend_cslot_reg, pend_cslot_next;

    logic [31:0]           tag_mem  [DEPTH];
    logic [DATA_WIDTH-1:0] data_mem [DEPTH];
    logic [31:0]           tag_rd_reg;
    logic [DATA_WIDTH-1:0] data_rd_reg;
    logic                  tag_ok_reg, tag_ok_next;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic                  rd_en;
    logic [AW-1:0]         tag_raddr, data_raddr;

    logic                  rsp_valid_reg, rsp_valid_next;
    brq_pkg::rsp_t         rsp_reg, rsp_next;

    logic [RW-1:0]         head_idx;
    logic [31:0]           head_cursor;
    logic [AW-1:0]         head_cslot;
    logic [31:0]           count_inc;
    logic [AW-1:0]         inc_slot;
    logic [31:0]           tag_eff, tag_inc, tag_diff;

    assign head_idx    = RW'(q_op.reader);
    assign head_cursor = cursor_reg[head_idx];
    assign head_cslot  = cslot_reg[head_idx];
    assign count_inc   = count_reg + 32'd1;
    assign inc_slot    = (count_inc == 32'd0) ? '0 : slot_inc(wslot_reg);
    assign tag_eff     = tag_ok_reg ? tag_rd_reg : 32'd0;
    assign tag_inc     = tag_eff + 32'd1;
    assign tag_diff    = tag_eff - pend_cursor_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brq_pkg::ST_IDLE:
            begin
                if (!q_status.empty && (q_op.kind inside {brq_pkg::OP_READ, brq_pkg::OP_NEWEST}))
                begin
                    state_next = brq_pkg::ST_LOOKUP;
                end
            end
            brq_pkg::ST_LOOKUP:
            begin
                state_next = brq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = brq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop            = 1'b0;
        count_next       = count_reg;
        wslot_next       = wslot_reg;
        filled_next      = filled_reg;
        cur_we           = 1'b0;
        cur_idx          = head_idx;
        cur_val          = count_inc;
        cur_slot         = inc_slot;
        pend_kind_next   = pend_kind_reg;
        pend_idx_next    = pend_idx_reg;
        pend_cursor_next = pend_cursor_reg;
        pend_cslot_next  = pend_cslot_reg;
        mem_we           = 1'b0;
        mem_waddr        = inc_slot;
        rd_en            = 1'b0;
        tag_raddr        = head_cslot;
        data_raddr       = (q_op.kind == brq_pkg::OP_NEWEST) ? wslot_reg : head_cslot;
        tag_ok_next      = filled_reg || (head_cslot != '0 && 32'(head_cslot) <= count_reg);
        rsp_valid_next   = 1'b0;
        rsp_next         = '0;
        case (state_reg)
            brq_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    case (q_op.kind)
                        brq_pkg::OP_WRITE:
                        begin
                            count_next = count_inc;
                            wslot_next = inc_slot;
                            if (count_inc == 32'(DEPTH))
                            begin
                                filled_next = 1'b1;
                            end
                            mem_we            = 1'b1;
                            rsp_valid_next    = 1'b1;
                            rsp_next.found    = 1'b1;
                            rsp_next.data_out = 64'(q_op.payload[DATA_WIDTH-1:0]);
                            rsp_next.seq_out  = count_inc;
                        end
                        brq_pkg::OP_ATTACH:
                        begin
                            cur_we           = 1'b1;
                            rsp_valid_next   = 1'b1;
                            rsp_next.found   = 1'b1;
                            rsp_next.seq_out = count_inc;
                        end
                        brq_pkg::OP_READ, brq_pkg::OP_NEWEST:
                        begin
                            rd_en            = 1'b1;
                            pend_kind_next   = q_op.kind;
                            pend_idx_next    = head_idx;
                            pend_cursor_next = head_cursor;
                            pend_cslot_next  = head_cslot;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            brq_pkg::ST_LOOKUP:
            begin
                rsp_valid_next = 1'b1;
                if (!tag_diff[31])
                begin
                    cur_we            = 1'b1;
                    cur_idx           = pend_idx_reg;
                    rsp_next.found    = 1'b1;
                    rsp_next.data_out = 64'(data_rd_reg);
                    if (pend_kind_reg == brq_pkg::OP_READ)
                    begin
                        cur_val          = tag_inc;
                        cur_slot         = (tag_inc == 32'd0) ? '0 : slot_inc(pend_cslot_reg);
                        rsp_next.seq_out = tag_eff;
                    end
                    else
                    begin
                        rsp_next.seq_out = count_reg;
                    end
                end
            end
            default:
            begin
                rsp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brq_pkg::ST_IDLE;
            count_reg     <= '0;
            wslot_reg     <= '0;
            filled_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wslot_reg     <= wslot_next;
            filled_reg    <= filled_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_READERS; i++)
            begin
                cursor_reg[i] <= 32'd1;
                cslot_reg[i]  <= AW'(1);
            end
        end
        else if (cur_we)
        begin
            cursor_reg[cur_idx] <= cur_val;
            cslot_reg[cur_idx]  <= cur_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg   <= pend_kind_next;
        pend_idx_reg    <= pend_idx_next;
        pend_cursor_reg <= pend_cursor_next;
        pend_cslot_reg  <= pend_cslot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= count_inc;
        end
        if (rd_en)
        begin
            tag_rd_reg <= tag_mem[tag_raddr];
            tag_ok_reg <= tag_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            data_mem[mem_waddr] <= q_op.payload[DATA_WIDTH-1:0];
        end
        if (rd_en)
        begin
            data_rd_reg <= data_mem[data_raddr];
        end
    end

    `BRQ_ASSERT_NOW(a_empty_rsp_zero, rsp_valid_reg && !rsp_reg.found,
        rsp_reg.data_out == 64'd0 && rsp_reg.seq_out == 32'd0, "empty result carries data")
    `BRQ_ASSERT_NEXT(a_lookup_answers, state_reg == brq_pkg::ST_LOOKUP,
        rsp_valid_reg, "slot lookup gave no result")
    `BRQ_ASSERT_NOW(a_filled_sticky, 1'b1, !$fell(filled_reg), "ring fill flag dropped")
    `BRQ_ASSERT_NOW(a_wslot_tracks, !filled_reg, 32'(wslot_reg) == count_reg,
        "write slot out of step with write counter")

endmodule

### rtl/broadcast_ring_queue_top.sv
// top level of the broadcast ring queue
//
//  channel   handshake          transfer when           payload
//  command   start / busy       start && !busy          cmd (brq_pkg::cmd_t)
//  result    rsp_valid strobe   rsp_valid, one cycle    rsp (brq_pkg::rsp_t)
//
//  write, attach and rejected ops are answered from the idle state; read and read newest
//  pass through a lookup state (registered read of the slot tag and data memories)
//  a command is written into a two-entry op queue and reaches the back end from its head
//  busy rises only while the op queue is full; results cannot be held off
//  no clearing pass after reset: a fill count marks which slot tags are written
module broadcast_ring_queue_top #(
    parameter int DEPTH       = 1024,
    parameter int NUM_READERS = 8,
    parameter int DATA_WIDTH  = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  brq_pkg::cmd_t cmd,
    output logic          rsp_valid,
    output brq_pkg::rsp_t rsp
);

    brq_pkg::queue_status_t q_status;
    brq_pkg::op_t           push_op;
    brq_pkg::op_t           head_op;
    logic                   push;
    logic                   pop;

    brq_front #(
        .NUM_READERS (NUM_READERS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_front (
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .q_status (q_status),
        .push     (push),
        .push_op  (push_op)
    );

    brq_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    brq_back #(
        .DEPTH       (DEPTH),
        .NUM_READERS (NUM_READERS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_op      (head_op),
        .q_pop     (pop),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
